@@ hdl/lfpd_pkg.sv @@
// ---------------------------------------------------------------------------
// Line follower PID drive package
// Shared widths, register codes, reset values and the sensor weight table.
// ---------------------------------------------------------------------------
package lfpd_pkg;

    localparam int SENSOR_COUNT  = 9;
    localparam int SAMPLE_BITS   = 10;
    localparam int NOW_BITS      = 32;
    localparam int GAIN_BITS     = 24;
    localparam int LIMIT_BITS    = 12;
    localparam int REFRESH_BITS  = 16;
    localparam int DUTY_BITS     = 8;
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 24;
    localparam int WEIGHT_BITS   = 5;
    localparam int DEN_BITS      = 4;
    localparam int MUL_B_BITS    = 25;
    localparam int PSAT_BITS     = 26;
    localparam int CORR_BITS     = 11;
    localparam int CMD_BITS      = 12;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_LINE_THRESHOLD = 3'd0,
        CFG_GAIN_P         = 3'd1,
        CFG_GAIN_I         = 3'd2,
        CFG_GAIN_D         = 3'd3,
        CFG_INTEGRAL_LIMIT = 3'd4,
        CFG_REFRESH_MS     = 3'd5,
        CFG_NOMINAL_SPEED  = 3'd6
    } t_cfg_idx;

    localparam logic [SAMPLE_BITS-1:0]  RST_LINE_THRESHOLD = 10'd300;
    localparam logic [GAIN_BITS-1:0]    RST_GAIN_P         = 24'd282624;
    localparam logic [GAIN_BITS-1:0]    RST_GAIN_I         = 24'd123;
    localparam logic [GAIN_BITS-1:0]    RST_GAIN_D         = 24'd1413120;
    localparam logic [LIMIT_BITS-1:0]   RST_INTEGRAL_LIMIT = 12'd650;
    localparam logic [REFRESH_BITS-1:0] RST_REFRESH_MS     = 16'd15;
    localparam logic [DUTY_BITS-1:0]    RST_NOMINAL_SPEED  = 8'd180;

    // Sensor weights, leftmost sensor first.
    localparam logic signed [WEIGHT_BITS-1:0] SENSOR_WEIGHT [SENSOR_COUNT] = '{
        -5'sd8, -5'sd4, -5'sd2, -5'sd1, 5'sd0, 5'sd1, 5'sd2, 5'sd4, 5'sd8
    };

    localparam logic signed [PSAT_BITS-1:0] PROD_LIMIT = 26'sd33554431;
    localparam logic signed [CORR_BITS-1:0] CORR_LIMIT = 11'sd1023;
    localparam logic signed [CMD_BITS-1:0]  DRIVE_MAX  = 12'sd255;

endpackage

@@ hdl/lfpd_sample_if.sv @@
// ---------------------------------------------------------------------------
// Sensor sample channel
// Carries one frame of nine reflectance samples and a millisecond timestamp.
// ---------------------------------------------------------------------------
interface lfpd_sample_if;

    logic                               valid;
    logic                               ready;
    logic [lfpd_pkg::SAMPLE_BITS-1:0]   sample_0;
    logic [lfpd_pkg::SAMPLE_BITS-1:0]   sample_1;
    logic [lfpd_pkg::SAMPLE_BITS-1:0]   sample_2;
    logic [lfpd_pkg::SAMPLE_BITS-1:0]   sample_3;
    logic [lfpd_pkg::SAMPLE_BITS-1:0]   sample_4;
    logic [lfpd_pkg::SAMPLE_BITS-1:0]   sample_5;
    logic [lfpd_pkg::SAMPLE_BITS-1:0]   sample_6;
    logic [lfpd_pkg::SAMPLE_BITS-1:0]   sample_7;
    logic [lfpd_pkg::SAMPLE_BITS-1:0]   sample_8;
    logic [lfpd_pkg::NOW_BITS-1:0]      now_ms;

    modport source (
        output valid, sample_0, sample_1, sample_2, sample_3, sample_4,
               sample_5, sample_6, sample_7, sample_8, now_ms,
        input  ready
    );

    modport sink (
        input  valid, sample_0, sample_1, sample_2, sample_3, sample_4,
               sample_5, sample_6, sample_7, sample_8, now_ms,
        output ready
    );

endinterface

@@ hdl/lfpd_drive_if.sv @@
// ---------------------------------------------------------------------------
// Motor drive channel
// Carries the four PWM duties and the line-seen flag of one result.
// ---------------------------------------------------------------------------
interface lfpd_drive_if;

    logic                           valid;
    logic                           ready;
    logic [lfpd_pkg::DUTY_BITS-1:0] left_forward_duty;
    logic [lfpd_pkg::DUTY_BITS-1:0] left_reverse_duty;
    logic [lfpd_pkg::DUTY_BITS-1:0] right_forward_duty;
    logic [lfpd_pkg::DUTY_BITS-1:0] right_reverse_duty;
    logic                           line_seen;

    modport source (
        output valid, left_forward_duty, left_reverse_duty,
               right_forward_duty, right_reverse_duty, line_seen,
        input  ready
    );

    modport sink (
        input  valid, left_forward_duty, left_reverse_duty,
               right_forward_duty, right_reverse_duty, line_seen,
        output ready
    );

endinterface

@@ hdl/lfpd_div.sv @@
// ---------------------------------------------------------------------------
// Serial unsigned divider
// Restoring division, one quotient bit per cycle; done pulses for one cycle.
// ---------------------------------------------------------------------------
module lfpd_div #(
    parameter int DIVIDEND_BITS = 17,
    parameter int DIVISOR_BITS  = 32
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic [DIVIDEND_BITS-1:0] i_dividend,
    input  logic [DIVISOR_BITS-1:0]  i_divisor,
    output logic [DIVIDEND_BITS-1:0] o_quotient,
    output logic                     o_done
);

    localparam int CNT_BITS = $clog2(DIVIDEND_BITS + 1);

    logic [DIVISOR_BITS-1:0]  r_rem;
    logic [DIVIDEND_BITS-1:0] r_quo;
    logic [DIVISOR_BITS-1:0]  r_dvs;
    logic [CNT_BITS-1:0]      r_cnt;
    logic                     r_busy;
    logic                     r_done;

    logic [DIVISOR_BITS:0]    w_trial;
    logic [DIVISOR_BITS:0]    w_sub;
    logic                     w_ge;

    assign w_trial = {r_rem, r_quo[DIVIDEND_BITS-1]};
    assign w_sub   = w_trial - {1'b0, r_dvs};
    assign w_ge    = w_trial >= {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_BITS'(DIVIDEND_BITS);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_BITS'(1);
                if (r_cnt == CNT_BITS'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // The quotient shifts in where the dividend bits shift out.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_sub[DIVISOR_BITS-1:0] : w_trial[DIVISOR_BITS-1:0];
            r_quo <= {r_quo[DIVIDEND_BITS-2:0], w_ge};
        end
    end

    assign o_quotient = r_quo;
    assign o_done     = r_done;

endmodule

@@ hdl/line_follower_pid_drive_unit.sv @@
// ---------------------------------------------------------------------------
// Line follower PID motor drive
// Line position from nine reflectance sensors, a PID step on a millisecond
// schedule, and forward/reverse PWM duties for two motors.
//
// A word that runs the PID step goes through two passes of the serial divider
// (error centroid, then derivative over dt). A word that comes too soon takes
// only the first pass, and a word without the line goes straight to the result
// register.
// One word is in work at a time; a new word is taken only back in idle.
// Reset (synchronous, active low) restores register defaults and clears PID state.
// ---------------------------------------------------------------------------
module line_follower_pid_drive_unit #(
    parameter int FRACTION_BITS = 12
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [lfpd_pkg::CFG_IDX_BITS-1:0]   i_cfg_idx,
    input  logic [lfpd_pkg::CFG_DATA_BITS-1:0]  i_cfg_data,
    lfpd_sample_if.sink                         i_sample,
    lfpd_drive_if.source                        o_drive
);

    import lfpd_pkg::*;

    localparam int EW   = FRACTION_BITS + 5;     // error
    localparam int EW1  = EW + 1;                // error difference
    localparam int DVW  = FRACTION_BITS + 5;     // divider dividend
    localparam int DRW  = FRACTION_BITS + 6;     // derivative
    localparam int IW   = FRACTION_BITS + 13;    // integral
    localparam int SW   = ((IW > PSAT_BITS) ? IW : PSAT_BITS) + 1;
    localparam int MA   = IW;                    // multiplier signed operand
    localparam int PW   = MA + MUL_B_BITS + 1;   // product
    localparam int ACW  = PW + 2;                // accumulator
    localparam int CW   = ACW - 2 * FRACTION_BITS;
    localparam int MAGW = WEIGHT_BITS - 1;
    localparam logic signed [ACW-1:0] RND_BIAS =
        ACW'((64'(1) << (2 * FRACTION_BITS)) - 64'(1));

    typedef enum logic [17:0] {
        S_IDLE      = 18'h00001,
        S_DIVE_GO   = 18'h00002,
        S_DIVE_WAIT = 18'h00004,
        S_ERR       = 18'h00008,
        S_DIFF      = 18'h00010,
        S_DIVD_GO   = 18'h00020,
        S_DIVD_WAIT = 18'h00040,
        S_DER       = 18'h00080,
        S_MUL_ED    = 18'h00100,
        S_SAT       = 18'h00200,
        S_INTEG     = 18'h00400,
        S_MUL_P     = 18'h00800,
        S_MUL_I     = 18'h01000,
        S_MUL_D     = 18'h02000,
        S_SUM       = 18'h04000,
        S_CORR      = 18'h08000,
        S_CMD       = 18'h10000,
        S_OUT       = 18'h20000
    } t_state;

    typedef struct packed {
        logic [DUTY_BITS-1:0] fwd;
        logic [DUTY_BITS-1:0] rev;
    } t_duty_pair;

    function automatic t_duty_pair f_split(input logic signed [CMD_BITS-1:0] cmd);
        t_duty_pair              res;
        logic signed [CMD_BITS-1:0] lim;
        lim = cmd;
        if (cmd > DRIVE_MAX) begin
            lim = DRIVE_MAX;
        end else if (cmd < -DRIVE_MAX) begin
            lim = -DRIVE_MAX;
        end
        if (lim[CMD_BITS-1]) begin
            res.fwd = '0;
            res.rev = DUTY_BITS'(-lim);
        end else begin
            res.fwd = DUTY_BITS'(lim);
            res.rev = '0;
        end
        return res;
    endfunction

    // Configuration registers
    logic [SAMPLE_BITS-1:0]  r_line_threshold;
    logic [GAIN_BITS-1:0]    r_gain_p;
    logic [GAIN_BITS-1:0]    r_gain_i;
    logic [GAIN_BITS-1:0]    r_gain_d;
    logic [LIMIT_BITS-1:0]   r_integral_limit;
    logic [REFRESH_BITS-1:0] r_refresh_ms;
    logic [DUTY_BITS-1:0]    r_nominal_speed;

    // PID state
    logic signed [EW-1:0]    r_last_error;
    logic signed [EW-1:0]    r_prev_error;
    logic signed [IW-1:0]    r_integral;
    logic [NOW_BITS-1:0]     r_last_update;

    // Working registers
    t_state                  r_state;
    logic [NOW_BITS-1:0]     r_now;
    logic [MAGW-1:0]         r_num_mag;
    logic                    r_num_neg;
    logic [DEN_BITS-1:0]     r_den;
    logic [NOW_BITS-1:0]     r_dt;
    logic [DVW-1:0]          r_diff_mag;
    logic                    r_diff_neg;
    logic signed [DRW-1:0]   r_deriv;
    logic signed [PW-1:0]    r_prod;
    logic signed [PSAT_BITS-1:0] r_psat;
    logic signed [ACW-1:0]   r_acc;
    logic signed [CORR_BITS-1:0] r_corr;
    logic signed [CMD_BITS-1:0]  r_lcmd;
    logic signed [CMD_BITS-1:0]  r_rcmd;
    logic                    r_line;

    // Result register
    logic                    r_out_valid;
    t_duty_pair              r_out_left;
    t_duty_pair              r_out_right;
    logic                    r_out_line;

    logic [SAMPLE_BITS-1:0]  w_samples [SENSOR_COUNT];
    logic signed [WEIGHT_BITS-1:0] w_num;
    logic [DEN_BITS-1:0]     w_den;
    logic                    w_in_fire;
    logic                    w_div_start;
    logic [DVW-1:0]          w_dividend;
    logic [NOW_BITS-1:0]     w_divisor;
    logic [DVW-1:0]          w_quot;
    logic                    w_div_done;
    logic signed [EW-1:0]    w_qe;
    logic signed [EW-1:0]    w_err;
    logic signed [DRW-1:0]   w_qd;
    logic [NOW_BITS-1:0]     w_dt;
    logic [REFRESH_BITS-1:0] w_need;
    logic signed [EW1-1:0]   w_diff;
    logic signed [MA-1:0]    w_mul_a;
    logic [MUL_B_BITS-1:0]   w_mul_b;
    logic signed [PW-1:0]    w_mul_p;
    logic signed [SW-1:0]    w_isum;
    logic signed [SW-1:0]    w_lim;
    logic signed [ACW-1:0]   w_rnd;
    logic signed [CW-1:0]    w_shift;
    logic signed [CMD_BITS-1:0] w_nom;
    logic                    w_out_load;

    assign w_samples[0] = i_sample.sample_0;
    assign w_samples[1] = i_sample.sample_1;
    assign w_samples[2] = i_sample.sample_2;
    assign w_samples[3] = i_sample.sample_3;
    assign w_samples[4] = i_sample.sample_4;
    assign w_samples[5] = i_sample.sample_5;
    assign w_samples[6] = i_sample.sample_6;
    assign w_samples[7] = i_sample.sample_7;
    assign w_samples[8] = i_sample.sample_8;

    assign i_sample.ready = (r_state == S_IDLE);
    assign w_in_fire      = i_sample.valid && (r_state == S_IDLE);

    // Weight sum and count of the sensors that see the line.
    always_comb begin
        w_num = '0;
        w_den = '0;
        for (int k = 0; k < SENSOR_COUNT; k++) begin
            if (w_samples[k] <= r_line_threshold) begin
                w_num = w_num + SENSOR_WEIGHT[k];
                w_den = w_den + DEN_BITS'(1);
            end
        end
    end

    // Divider operands: the centroid first, then the error change over dt.
    always_comb begin
        w_div_start = 1'b0;
        w_dividend  = '0;
        w_divisor   = '0;
        case (r_state)
            S_DIVE_GO: begin
                w_div_start = 1'b1;
                w_dividend  = DVW'({r_num_mag, {FRACTION_BITS{1'b0}}});
                w_divisor   = NOW_BITS'(r_den);
            end
            S_DIVD_GO: begin
                w_div_start = 1'b1;
                w_dividend  = r_diff_mag;
                w_divisor   = r_dt;
            end
            default: begin
                w_div_start = 1'b0;
            end
        endcase
    end

    lfpd_div #(
        .DIVIDEND_BITS (DVW),
        .DIVISOR_BITS  (NOW_BITS)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_dividend),
        .i_divisor  (w_divisor),
        .o_quotient (w_quot),
        .o_done     (w_div_done)
    );

    assign w_qe   = $signed(w_quot);
    assign w_err  = r_num_neg ? -w_qe : w_qe;
    assign w_qd   = $signed({1'b0, w_quot});
    assign w_dt   = r_now - r_last_update;
    assign w_need = (r_refresh_ms == '0) ? REFRESH_BITS'(1) : r_refresh_ms;
    assign w_diff = EW1'(r_last_error) - EW1'(r_prev_error);

    // Shared multiplier operand selection.
    always_comb begin
        w_mul_a = '0;
        w_mul_b = '0;
        case (r_state)
            S_MUL_ED: begin
                w_mul_a = MA'(r_last_error);
                w_mul_b = r_dt[MUL_B_BITS-1:0];
            end
            S_MUL_P: begin
                w_mul_a = MA'(r_last_error);
                w_mul_b = MUL_B_BITS'(r_gain_p);
            end
            S_MUL_I: begin
                w_mul_a = r_integral;
                w_mul_b = MUL_B_BITS'(r_gain_i);
            end
            S_MUL_D: begin
                w_mul_a = MA'(r_deriv);
                w_mul_b = MUL_B_BITS'(r_gain_d);
            end
            default: begin
                w_mul_a = '0;
            end
        endcase
    end

    assign w_mul_p = w_mul_a * $signed({1'b0, w_mul_b});

    assign w_isum  = SW'(r_integral) + SW'(r_psat);
    assign w_lim   = $signed(SW'({r_integral_limit, {FRACTION_BITS{1'b0}}}));

    // Truncation toward zero of the 2F-fraction sum.
    assign w_rnd   = r_acc + (r_acc[ACW-1] ? RND_BIAS : ACW'(0));
    assign w_shift = CW'(w_rnd >>> (2 * FRACTION_BITS));

    assign w_nom      = $signed(CMD_BITS'(r_nominal_speed));
    assign w_out_load = (r_state == S_OUT) && (!r_out_valid || o_drive.ready);

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_threshold <= RST_LINE_THRESHOLD;
            r_gain_p         <= RST_GAIN_P;
            r_gain_i         <= RST_GAIN_I;
            r_gain_d         <= RST_GAIN_D;
            r_integral_limit <= RST_INTEGRAL_LIMIT;
            r_refresh_ms     <= RST_REFRESH_MS;
            r_nominal_speed  <= RST_NOMINAL_SPEED;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_LINE_THRESHOLD: r_line_threshold <= i_cfg_data[SAMPLE_BITS-1:0];
                CFG_GAIN_P:         r_gain_p         <= i_cfg_data[GAIN_BITS-1:0];
                CFG_GAIN_I:         r_gain_i         <= i_cfg_data[GAIN_BITS-1:0];
                CFG_GAIN_D:         r_gain_d         <= i_cfg_data[GAIN_BITS-1:0];
                CFG_INTEGRAL_LIMIT: r_integral_limit <= i_cfg_data[LIMIT_BITS-1:0];
                CFG_REFRESH_MS:     r_refresh_ms     <= i_cfg_data[REFRESH_BITS-1:0];
                CFG_NOMINAL_SPEED:  r_nominal_speed  <= i_cfg_data[DUTY_BITS-1:0];
                default: begin
                end
            endcase
        end
    end

    // Sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_last_error  <= '0;
            r_prev_error  <= '0;
            r_integral    <= '0;
            r_last_update <= '0;
        end else begin
            r_prod <= w_mul_p;
            case (r_state)
                S_IDLE: begin
                    if (w_in_fire) begin
                        r_now     <= i_sample.now_ms;
                        r_num_neg <= w_num[WEIGHT_BITS-1];
                        r_num_mag <= w_num[WEIGHT_BITS-1] ? MAGW'(-w_num) : MAGW'(w_num);
                        r_den     <= w_den;
                        if (w_den == '0) begin
                            // No line: spin toward the side of the last error.
                            r_line <= 1'b0;
                            if (r_last_error > 0) begin
                                r_lcmd <= w_nom;
                                r_rcmd <= -w_nom;
                            end else if (r_last_error < 0) begin
                                r_lcmd <= -w_nom;
                                r_rcmd <= w_nom;
                            end else begin
                                r_lcmd <= '0;
                                r_rcmd <= '0;
                            end
                            r_state <= S_OUT;
                        end else begin
                            r_line  <= 1'b1;
                            r_state <= S_DIVE_GO;
                        end
                    end
                end
                S_DIVE_GO: begin
                    r_state <= S_DIVE_WAIT;
                end
                S_DIVE_WAIT: begin
                    if (w_div_done) begin
                        r_state <= S_ERR;
                    end
                end
                S_ERR: begin
                    r_last_error <= w_err;
                    r_dt         <= w_dt;
                    if (w_dt >= NOW_BITS'(w_need)) begin
                        r_state <= S_DIFF;
                    end else begin
                        r_corr  <= '0;
                        r_state <= S_CMD;
                    end
                end
                S_DIFF: begin
                    r_diff_neg <= w_diff[EW1-1];
                    r_diff_mag <= w_diff[EW1-1] ? DVW'(-w_diff) : DVW'(w_diff);
                    r_state    <= S_DIVD_GO;
                end
                S_DIVD_GO: begin
                    r_state <= S_DIVD_WAIT;
                end
                S_DIVD_WAIT: begin
                    if (w_div_done) begin
                        r_state <= S_DER;
                    end
                end
                S_DER: begin
                    r_deriv <= r_diff_neg ? -w_qd : w_qd;
                    r_state <= S_MUL_ED;
                end
                S_MUL_ED: begin
                    r_state <= S_SAT;
                end
                S_SAT: begin
                    // Only the low dt bits went through the multiplier; a larger
                    // dt with a nonzero error always saturates.
                    if ((r_dt[NOW_BITS-1:MUL_B_BITS] != '0) && (r_last_error != '0)) begin
                        r_psat <= r_last_error[EW-1] ? -PROD_LIMIT : PROD_LIMIT;
                    end else if (r_prod > PW'(PROD_LIMIT)) begin
                        r_psat <= PROD_LIMIT;
                    end else if (r_prod < -PW'(PROD_LIMIT)) begin
                        r_psat <= -PROD_LIMIT;
                    end else begin
                        r_psat <= PSAT_BITS'(r_prod);
                    end
                    r_state <= S_INTEG;
                end
                S_INTEG: begin
                    if (w_isum > w_lim) begin
                        r_integral <= IW'(w_lim);
                    end else if (w_isum < -w_lim) begin
                        r_integral <= IW'(-w_lim);
                    end else begin
                        r_integral <= IW'(w_isum);
                    end
                    r_prev_error  <= r_last_error;
                    r_last_update <= r_now;
                    r_state       <= S_MUL_P;
                end
                S_MUL_P: begin
                    r_state <= S_MUL_I;
                end
                S_MUL_I: begin
                    r_acc   <= ACW'(r_prod);
                    r_state <= S_MUL_D;
                end
                S_MUL_D: begin
                    r_acc   <= r_acc + ACW'(r_prod);
                    r_state <= S_SUM;
                end
                S_SUM: begin
                    r_acc   <= r_acc + ACW'(r_prod);
                    r_state <= S_CORR;
                end
                S_CORR: begin
                    if (w_shift > CW'(CORR_LIMIT)) begin
                        r_corr <= CORR_LIMIT;
                    end else if (w_shift < -CW'(CORR_LIMIT)) begin
                        r_corr <= -CORR_LIMIT;
                    end else begin
                        r_corr <= CORR_BITS'(w_shift);
                    end
                    r_state <= S_CMD;
                end
                S_CMD: begin
                    r_lcmd  <= w_nom + CMD_BITS'(r_corr);
                    r_rcmd  <= w_nom - CMD_BITS'(r_corr);
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (w_out_load) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_drive.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out_left  <= f_split(r_lcmd);
            r_out_right <= f_split(r_rcmd);
            r_out_line  <= r_line;
        end
    end

    assign o_drive.valid              = r_out_valid;
    assign o_drive.left_forward_duty  = r_out_left.fwd;
    assign o_drive.left_reverse_duty  = r_out_left.rev;
    assign o_drive.right_forward_duty = r_out_right.fwd;
    assign o_drive.right_reverse_duty = r_out_right.rev;
    assign o_drive.line_seen          = r_out_line;

endmodule

@@ dv/testbench.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Line follower PID drive testbench
// Sends sensor words through the sample channel and checks every drive word
// against a predictor of the centroid error, the PID step and the duty split.
// It starts with a table of directed words, then runs random words under
// several register settings, with random idle bursts on both channels.
// ---------------------------------------------------------------------------
module testbench;

    import lfpd_pkg::*;

    localparam int FRAC           = 12;
    localparam int PHASES         = 6;
    localparam int PHASE_WORDS    = 240;
    localparam int SETTLE_CYCLES  = 2 * FRAC + 40;
    localparam logic [CFG_IDX_BITS-1:0] CFG_SPARE_IDX = 3'd7;

    typedef struct packed {
        logic [DUTY_BITS-1:0] left_fwd;
        logic [DUTY_BITS-1:0] left_rev;
        logic [DUTY_BITS-1:0] right_fwd;
        logic [DUTY_BITS-1:0] right_rev;
        logic                 line_seen;
    } t_drive_word;

    typedef struct {
        logic [SAMPLE_BITS-1:0] sample [SENSOR_COUNT];
        logic [NOW_BITS-1:0]    now_ms;
    } t_sensor_frame;

    typedef struct packed {
        logic [SENSOR_COUNT-1:0] line_mask;
        logic [SAMPLE_BITS-1:0]  on_level;
        logic [SAMPLE_BITS-1:0]  off_level;
        logic [NOW_BITS-1:0]     now_ms;
        logic                    typed;
        t_drive_word             want;
    } t_bench_row;

    // Sensors in line_mask get on_level, the others off_level. The duties are
    // typed in only where they follow at once from reset state or the no-line rule.
    localparam t_bench_row OPENING [20] = '{
        '{9'h000, 10'd0,   10'd1023, 32'd0,          1'b1, '{8'd0,   8'd0,   8'd0,   8'd0, 1'b0}},
        '{9'h1FF, 10'd0,   10'd0,    32'd0,          1'b1, '{8'd180, 8'd0,   8'd180, 8'd0, 1'b1}},
        '{9'h001, 10'd0,   10'd1023, 32'd5,          1'b1, '{8'd180, 8'd0,   8'd180, 8'd0, 1'b1}},
        '{9'h000, 10'd0,   10'd1023, 32'd6,          1'b1, '{8'd0,   8'd180, 8'd180, 8'd0, 1'b0}},
        '{9'h100, 10'd300, 10'd301,  32'd20,         1'b0, '0},
        '{9'h000, 10'd300, 10'd301,  32'd21,         1'b1, '{8'd180, 8'd0,   8'd0, 8'd180, 1'b0}},
        '{9'h00F, 10'd0,   10'd1023, 32'd40,         1'b0, '0},
        '{9'h010, 10'd0,   10'd1023, 32'd60,         1'b0, '0},
        '{9'h002, 10'd0,   10'd1023, 32'd80,         1'b0, '0},
        '{9'h004, 10'd0,   10'd1023, 32'd100,        1'b0, '0},
        '{9'h008, 10'd0,   10'd1023, 32'd120,        1'b0, '0},
        '{9'h020, 10'd0,   10'd1023, 32'd140,        1'b0, '0},
        '{9'h040, 10'd0,   10'd1023, 32'd160,        1'b0, '0},
        '{9'h080, 10'd0,   10'd1023, 32'd180,        1'b0, '0},
        '{9'h1E0, 10'd0,   10'd1023, 32'hFFFF_FFF0,  1'b0, '0},
        '{9'h183, 10'd0,   10'd1023, 32'hFFFF_FFF5,  1'b0, '0},
        '{9'h038, 10'd0,   10'd1023, 32'd10,         1'b0, '0},
        '{9'h0FE, 10'd150, 10'd800,  32'd30,         1'b0, '0},
        '{9'h155, 10'd300, 10'd1023, 32'd50,         1'b0, '0},
        '{9'h0AA, 10'd0,   10'd301,  32'd51,         1'b0, '0}
    };

    logic                      i_clk = 1'b0;
    logic                      i_rst_n;
    logic                      i_cfg_we;
    logic [CFG_IDX_BITS-1:0]   i_cfg_idx;
    logic [CFG_DATA_BITS-1:0]  i_cfg_data;

    lfpd_sample_if smp ();
    lfpd_drive_if  drv ();

    line_follower_pid_drive_unit dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_sample   (smp),
        .o_drive    (drv)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Register copies and PID state of the predictor.
    logic [SAMPLE_BITS-1:0]    threshold_q;
    logic [GAIN_BITS-1:0]      gain_p_q;
    logic [GAIN_BITS-1:0]      gain_i_q;
    logic [GAIN_BITS-1:0]      gain_d_q;
    logic [LIMIT_BITS-1:0]     int_limit_q;
    logic [REFRESH_BITS-1:0]   refresh_q;
    logic [DUTY_BITS-1:0]      speed_q;
    logic signed [16:0]        last_err_q;
    logic signed [16:0]        prev_err_q;
    logic signed [25:0]        integral_q;
    logic [NOW_BITS-1:0]       last_update_q;

    t_drive_word pending_drives [$];
    int          mismatch_count = 0;
    int          word_count = 0;
    int          stall_left = 0;
    bit          idling = 1'b1;
    logic [NOW_BITS-1:0] clock_ms = '0;

    function automatic longint clamp_to(longint v, longint lo, longint hi);
        if (v < lo) return lo;
        if (v > hi) return hi;
        return v;
    endfunction

    function automatic void split_drive(input longint drive,
                                        output logic [DUTY_BITS-1:0] fwd,
                                        output logic [DUTY_BITS-1:0] rev);
        longint d;
        d = clamp_to(drive, -longint'(DRIVE_MAX), longint'(DRIVE_MAX));
        if (d >= 0) begin
            fwd = d[DUTY_BITS-1:0];
            rev = '0;
        end else begin
            d   = -d;
            fwd = '0;
            rev = d[DUTY_BITS-1:0];
        end
    endfunction

    function automatic t_drive_word drive_for_frame(t_sensor_frame f);
        longint num, den, err, corr, dt, need, deriv, prod, lim, integ, sum, left, right;
        logic [NOW_BITS-1:0] span;
        t_drive_word w;
        num  = 0;
        den  = 0;
        corr = 0;
        for (int i = 0; i < SENSOR_COUNT; i++) begin
            if (f.sample[i] <= threshold_q) begin
                num += longint'(SENSOR_WEIGHT[i]);
                den += 1;
            end
        end
        if (den == 0) begin
            // Search spin toward the side where the line was last seen.
            left  = 0;
            right = 0;
            if (last_err_q > 0) begin
                left  = speed_q;
                right = -longint'(speed_q);
            end else if (last_err_q < 0) begin
                left  = -longint'(speed_q);
                right = speed_q;
            end
            split_drive(left, w.left_fwd, w.left_rev);
            split_drive(right, w.right_fwd, w.right_rev);
            w.line_seen = 1'b0;
            return w;
        end
        err        = (num * (longint'(1) << FRAC)) / den;
        last_err_q = err[16:0];
        span       = f.now_ms - last_update_q;
        dt         = span;
        need       = (refresh_q == 0) ? 1 : refresh_q;
        if (dt >= need) begin
            deriv = (err - longint'(prev_err_q)) / dt;
            prod  = clamp_to(err * dt, -longint'(PROD_LIMIT), longint'(PROD_LIMIT));
            lim   = longint'(int_limit_q) << FRAC;
            integ = clamp_to(longint'(integral_q) + prod, -lim, lim);
            integral_q    = integ[25:0];
            prev_err_q    = err[16:0];
            last_update_q = f.now_ms;
            sum  = err * longint'(gain_p_q) + integ * longint'(gain_i_q)
                 + deriv * longint'(gain_d_q);
            corr = sum / (longint'(1) << (2 * FRAC));
            corr = clamp_to(corr, -longint'(CORR_LIMIT), longint'(CORR_LIMIT));
        end
        split_drive(longint'(speed_q) + corr, w.left_fwd, w.left_rev);
        split_drive(longint'(speed_q) - corr, w.right_fwd, w.right_rev);
        w.line_seen = 1'b1;
        return w;
    endfunction

    task automatic flag_mismatch(string msg);
        $display("mismatch at drive word %0d: %s", word_count, msg);
        mismatch_count++;
    endtask

    task automatic check_duty(string name, logic [DUTY_BITS-1:0] got,
                              logic [DUTY_BITS-1:0] want);
        if (got !== want)
            flag_mismatch($sformatf("%s is %0d, expected %0d", name, got, want));
    endtask

    // Output side: check each accepted word and stall ready in random bursts.
    always @(posedge i_clk) begin
        t_drive_word want;
        if (i_rst_n && drv.valid && drv.ready) begin
            if (pending_drives.size() == 0) begin
                flag_mismatch("word arrived with none expected");
            end else begin
                want = pending_drives.pop_front();
                check_duty("left_forward_duty", drv.left_forward_duty, want.left_fwd);
                check_duty("left_reverse_duty", drv.left_reverse_duty, want.left_rev);
                check_duty("right_forward_duty", drv.right_forward_duty, want.right_fwd);
                check_duty("right_reverse_duty", drv.right_reverse_duty, want.right_rev);
                if (drv.line_seen !== want.line_seen)
                    flag_mismatch($sformatf("line_seen is %0b, expected %0b",
                                            drv.line_seen, want.line_seen));
            end
            word_count++;
        end
        if (stall_left == 0 && idling && $urandom_range(0, 15) == 0)
            stall_left = $urandom_range(1, 13);
        if (stall_left > 0) begin
            stall_left--;
            drv.ready <= 1'b0;
        end else begin
            drv.ready <= 1'b1;
        end
    end

    task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        case (idx)
            CFG_LINE_THRESHOLD: threshold_q = data[SAMPLE_BITS-1:0];
            CFG_GAIN_P:         gain_p_q    = data[GAIN_BITS-1:0];
            CFG_GAIN_I:         gain_i_q    = data[GAIN_BITS-1:0];
            CFG_GAIN_D:         gain_d_q    = data[GAIN_BITS-1:0];
            CFG_INTEGRAL_LIMIT: int_limit_q = data[LIMIT_BITS-1:0];
            CFG_REFRESH_MS:     refresh_q   = data[REFRESH_BITS-1:0];
            CFG_NOMINAL_SPEED:  speed_q     = data[DUTY_BITS-1:0];
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    task automatic apply_settings(logic [SAMPLE_BITS-1:0] thr, logic [GAIN_BITS-1:0] gp,
                                  logic [GAIN_BITS-1:0] gi, logic [GAIN_BITS-1:0] gd,
                                  logic [LIMIT_BITS-1:0] lim, logic [REFRESH_BITS-1:0] rms,
                                  logic [DUTY_BITS-1:0] nom);
        write_reg(CFG_LINE_THRESHOLD, CFG_DATA_BITS'(thr));
        write_reg(CFG_GAIN_P, gp);
        write_reg(CFG_GAIN_I, gi);
        write_reg(CFG_GAIN_D, gd);
        write_reg(CFG_INTEGRAL_LIMIT, CFG_DATA_BITS'(lim));
        write_reg(CFG_REFRESH_MS, CFG_DATA_BITS'(rms));
        write_reg(CFG_NOMINAL_SPEED, CFG_DATA_BITS'(nom));
        // A write to the unused index must leave every register alone.
        write_reg(CFG_SPARE_IDX, CFG_DATA_BITS'($urandom));
        i_cfg_we <= 1'b0;
    endtask

    function automatic logic [SAMPLE_BITS-1:0] reading(bit on_line);
        if (on_line || threshold_q == '1)
            return SAMPLE_BITS'($urandom_range(0, threshold_q));
        return SAMPLE_BITS'($urandom_range(threshold_q + 1, (1 << SAMPLE_BITS) - 1));
    endfunction

    // Mostly a realistic line under one to three adjacent sensors and a clock
    // that steps around the refresh period; the rest is scatter, blank frames and raw noise.
    task automatic next_frame(output t_sensor_frame f);
        int pick, center, width;
        logic [SENSOR_COUNT-1:0] mask;
        pick = $urandom_range(0, 99);
        mask = '0;
        if (pick < 60) begin
            center = $urandom_range(0, SENSOR_COUNT - 1);
            width  = $urandom_range(1, 3);
            for (int i = 0; i < SENSOR_COUNT; i++)
                mask[i] = (i >= center && i < center + width);
        end else if (pick < 75) begin
            mask = SENSOR_COUNT'($urandom);
        end
        for (int i = 0; i < SENSOR_COUNT; i++)
            f.sample[i] = (pick >= 88) ? SAMPLE_BITS'($urandom) : reading(mask[i]);
        if (pick >= 88) begin
            f.now_ms = $urandom;
        end else begin
            clock_ms += $urandom_range(0, 2 * refresh_q + 1);
            f.now_ms = clock_ms;
        end
    endtask

    task automatic pace_sender();
        if (idling && $urandom_range(0, 5) == 0) begin
            smp.valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge i_clk);
        end
    endtask

    task automatic put_frame(t_sensor_frame f, logic typed, t_drive_word want);
        t_drive_word w;
        smp.valid    <= 1'b1;
        smp.sample_0 <= f.sample[0];
        smp.sample_1 <= f.sample[1];
        smp.sample_2 <= f.sample[2];
        smp.sample_3 <= f.sample[3];
        smp.sample_4 <= f.sample[4];
        smp.sample_5 <= f.sample[5];
        smp.sample_6 <= f.sample[6];
        smp.sample_7 <= f.sample[7];
        smp.sample_8 <= f.sample[8];
        smp.now_ms   <= f.now_ms;
        do @(posedge i_clk); while (!smp.ready);
        w = drive_for_frame(f);
        pending_drives.push_back(typed ? want : w);
    endtask

    task automatic drain_results();
        smp.valid <= 1'b0;
        while (pending_drives.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    initial begin
        t_sensor_frame f;
        t_bench_row    row;
        i_rst_n      <= 1'b0;
        i_cfg_we     <= 1'b0;
        i_cfg_idx    <= '0;
        i_cfg_data   <= '0;
        smp.valid    <= 1'b0;
        smp.sample_0 <= '0;
        smp.sample_1 <= '0;
        smp.sample_2 <= '0;
        smp.sample_3 <= '0;
        smp.sample_4 <= '0;
        smp.sample_5 <= '0;
        smp.sample_6 <= '0;
        smp.sample_7 <= '0;
        smp.sample_8 <= '0;
        smp.now_ms   <= '0;

        threshold_q   = RST_LINE_THRESHOLD;
        gain_p_q      = RST_GAIN_P;
        gain_i_q      = RST_GAIN_I;
        gain_d_q      = RST_GAIN_D;
        int_limit_q   = RST_INTEGRAL_LIMIT;
        refresh_q     = RST_REFRESH_MS;
        speed_q       = RST_NOMINAL_SPEED;
        last_err_q    = '0;
        prev_err_q    = '0;
        integral_q    = '0;
        last_update_q = '0;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int k = 0; k < $size(OPENING); k++) begin
            row = OPENING[k];
            for (int i = 0; i < SENSOR_COUNT; i++)
                f.sample[i] = row.line_mask[i] ? row.on_level : row.off_level;
            f.now_ms = row.now_ms;
            pace_sender();
            put_frame(f, row.typed, row.want);
        end
        clock_ms = OPENING[$size(OPENING) - 1].now_ms;

        for (int ph = 0; ph < PHASES; ph++) begin
            if (ph > 0) begin
                drain_results();
                case (ph)
                    1: apply_settings('1, '1, '1, '1, '1, '1, '1);
                    2: apply_settings('0, '0, '0, '0, '0, '0, '0);
                    3: apply_settings(SAMPLE_BITS'($urandom_range(200, 900)),
                                      GAIN_BITS'($urandom_range(0, 1 << 20)),
                                      GAIN_BITS'($urandom_range(0, 1 << 10)),
                                      GAIN_BITS'($urandom_range(0, 1 << 22)),
                                      LIMIT_BITS'($urandom),
                                      REFRESH_BITS'($urandom_range(1, 40)),
                                      DUTY_BITS'($urandom));
                    4: apply_settings(SAMPLE_BITS'(512), '1, GAIN_BITS'(4095), '1,
                                      '1, REFRESH_BITS'(1), '1);
                    default: apply_settings(RST_LINE_THRESHOLD, RST_GAIN_P, RST_GAIN_I,
                                            RST_GAIN_D, RST_INTEGRAL_LIMIT, RST_REFRESH_MS,
                                            RST_NOMINAL_SPEED);
                endcase
            end
            idling = (ph != 3 && ph != PHASES - 1);
            repeat (PHASE_WORDS) begin
                pace_sender();
                next_frame(f);
                put_frame(f, 1'b0, '0);
            end
        end

        drain_results();
        if (mismatch_count == 0) begin
            $display("[line_follower_pid_drive_unit] OK");
        end else begin
            $display("[line_follower_pid_drive_unit] ERROR");
        end
        $finish;
    end

    initial begin
        #(8_000_000);
        $display("[line_follower_pid_drive_unit] ERROR");
        $finish;
    end

endmodule
